// File: src/slrg_pkg.sv
`timescale 1ns / 1ps

package slrg_pkg;

  // table geometry and word size
  localparam int TABLE_LEN = 55;
  localparam int SHORT_LAG = 24;
  localparam int LAG_OFFSET = TABLE_LEN - SHORT_LAG;
  localparam int FILL_STRIDE = 21;
  localparam int WORD_W = 30;
  localparam int SEED_W = 32;
  localparam int IDX_W = $clog2(TABLE_LEN);

  // seeds fixed by the scheme
  localparam logic [SEED_W-1:0] RESET_SEED = 32'd123456789;
  localparam logic [SEED_W-1:0] ZERO_SEED_SUBST = 32'd1234556789;

  // item kinds
  localparam logic KIND_NEXT = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;

  // shared unit operations
  typedef enum logic {
    ALU_SUBMOD,
    ALU_REDUCE
  } alu_op_t;

  // table write port
  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } tbl_wr_t;

endpackage

// File: src/slrg_in_if.sv
`timescale 1ns / 1ps

interface slrg_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] seed_value;

  modport source (output valid, kind, seed_value, input ready);
  modport sink (input valid, kind, seed_value, output ready);
endinterface

// File: src/slrg_out_if.sv
`timescale 1ns / 1ps

interface slrg_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink (input valid, random_value, output ready);
endinterface

// File: src/slrg_alu.sv
`timescale 1ns / 1ps

module slrg_alu #(
  parameter int unsigned MODULUS = 1000000000
) (
  input  slrg_pkg::alu_op_t              op,
  input  logic [slrg_pkg::WORD_W:0]      a,
  input  slrg_pkg::word_t                b,
  output slrg_pkg::word_t                y
);
  import slrg_pkg::*;

  localparam logic [WORD_W:0] MOD_S = (WORD_W + 1)'(MODULUS);
  localparam logic [WORD_W+1:0] MOD_L = (WORD_W + 2)'(MODULUS);

  logic [WORD_W:0]   b_sel;
  logic [WORD_W+1:0] diff;
  logic [WORD_W+1:0] wrapped;
  logic              borrow;

  // one subtract with borrow, then modular fix-up or restore
  assign b_sel   = (op == ALU_REDUCE) ? MOD_S : {1'b0, b};
  assign diff    = {1'b0, a} - {1'b0, b_sel};
  assign borrow  = diff[WORD_W+1];
  assign wrapped = diff + MOD_L;

  always_comb begin
    if (!borrow) begin
      y = diff[WORD_W-1:0];
    end else if (op == ALU_REDUCE) begin
      y = a[WORD_W-1:0];
    end else begin
      y = wrapped[WORD_W-1:0];
    end
  end

endmodule

// File: src/slrg_table.sv
`timescale 1ns / 1ps

module slrg_table (
  input  logic              clk,
  input  slrg_pkg::tbl_wr_t wr,
  input  slrg_pkg::idx_t    rd_addr_a,
  input  slrg_pkg::idx_t    rd_addr_b,
  output slrg_pkg::word_t   rd_data_a,
  output slrg_pkg::word_t   rd_data_b
);
  import slrg_pkg::*;

  word_t mem [TABLE_LEN];
  word_t rd_a_r;
  word_t rd_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: src/subtractive_lagged_random_generator_unit.sv
`timescale 1ns / 1ps

// Subtractive lagged random generator, lags 24 and 55, words below MODULUS.
// in_item carries kind and seed_value; out_item carries random_value.
// A word is accepted on in_item when valid and ready are both high; ready
// is high only while the sequencer is idle.
// A next word (kind 0) reads the table entry at the read index and the entry
// 31 places on through the two registered read ports, subtracts them modulo
// MODULUS in the shared unit and writes the result back, so the table is
// refreshed one entry per read. The table read is registered; the write-back
// step then registers the result and writes the entry, waiting while the output
// register holds an untaken result, and returns the block to ready.
// A seed word (kind 1) gives no result and keeps ready low through the seed
// remainder (reciprocal quotient estimate, back-multiply and one compare and
// subtract), the stride-21 fill and two full regeneration passes (read, then
// subtract and write, per entry); the third warm-up pass is done lazily by the
// following reads.
// Reset runs the same seeding with 123456789, so ready rises when that seeding
// ends after rst_n is released.
// A result that the receiver has not taken holds in the output register;
// a next word may still be accepted, and it waits in its write-back step
// until the output register is free.
module subtractive_lagged_random_generator_unit #(
  parameter int unsigned MODULUS = 1000000000
) (
  input  logic              clk,
  input  logic              rst_n,
  slrg_in_if.sink           in_item,
  slrg_out_if.source        out_item
);
  import slrg_pkg::*;

  localparam logic [WORD_W:0] MOD_S = (WORD_W + 1)'(MODULUS);
  localparam logic [SEED_W-1:0] MOD_W = SEED_W'(MODULUS);
  localparam logic [SEED_W-1:0] MOD2 = SEED_W'(2 * MODULUS);
  localparam logic [SEED_W-1:0] RECIP = SEED_W'((64'd1 << SEED_W) / 64'(MODULUS));
  localparam idx_t LAST_IDX = IDX_W'(TABLE_LEN - 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_NEXT_WB   = 9'b000000010,
    S_QUOT      = 9'b000000100,
    S_BACK      = 9'b000001000,
    S_REDUCE    = 9'b000010000,
    S_FILL_HEAD = 9'b000100000,
    S_FILL      = 9'b001000000,
    S_RG_RD     = 9'b010000000,
    S_RG_WB     = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  idx_t              idx_r, idx_nxt;
  idx_t              cnt_r, cnt_nxt;
  logic              pass_r, pass_nxt;
  logic [SEED_W-1:0] mag_r, mag_nxt;
  logic [SEED_W-1:0] quot_r, quot_nxt;
  word_t             rem_r, rem_nxt;
  word_t             cur_r, cur_nxt;
  idx_t              stride_r, stride_nxt;
  word_t             out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic                accept_in;
  logic                commit;
  logic [SEED_W-1:0]   seed_mag;
  logic [2*SEED_W-1:0] quot_prod;
  logic [SEED_W-1:0]   back_prod;
  logic [IDX_W:0]      stride_sum;
  idx_t                fill_slot;
  idx_t                rd_addr;
  idx_t                rd_lag;
  word_t               rd_a;
  word_t               rd_b;
  tbl_wr_t             wr;
  alu_op_t             alu_op;
  logic [WORD_W:0]     alu_a;
  word_t               alu_b;
  word_t               alu_y;

  // entry 31 places on, wrapping round the table
  function automatic idx_t lag_of(input idx_t p);
    logic [IDX_W:0] s;
    s = {1'b0, p} + (IDX_W + 1)'(LAG_OFFSET);
    if (s >= (IDX_W + 1)'(TABLE_LEN)) begin
      s = s - (IDX_W + 1)'(TABLE_LEN);
    end
    return s[IDX_W-1:0];
  endfunction

  slrg_alu #(
    .MODULUS (MODULUS)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  slrg_table u_table (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr),
    .rd_addr_b (rd_lag),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // handshakes
  assign in_item.ready         = (state_r == S_IDLE);
  assign accept_in             = in_item.valid && in_item.ready;
  assign commit                = (state_r == S_NEXT_WB) && (!out_valid_r || out_item.ready);
  assign out_item.valid        = out_valid_r;
  assign out_item.random_value = out_r;

  // seed folding: magnitude, zero substituted
  always_comb begin
    if (in_item.seed_value[SEED_W-1]) begin
      seed_mag = ~in_item.seed_value + 32'd1;
    end else if (in_item.seed_value == '0) begin
      seed_mag = ZERO_SEED_SUBST;
    end else begin
      seed_mag = in_item.seed_value;
    end
  end

  // quotient estimate by reciprocal, never more than one below the true one
  assign quot_prod = {{SEED_W{1'b0}}, mag_r} * {{SEED_W{1'b0}}, RECIP};
  assign back_prod = quot_r * MOD_W;

  // stride-21 slot walk
  always_comb begin
    stride_sum = {1'b0, stride_r} + (IDX_W + 1)'(FILL_STRIDE);
    if (stride_sum >= (IDX_W + 1)'(TABLE_LEN)) begin
      stride_sum = stride_sum - (IDX_W + 1)'(TABLE_LEN);
    end
  end
  assign fill_slot = (stride_r == '0) ? LAST_IDX : stride_r - idx_t'(1);

  // table read addresses
  assign rd_addr = (state_r == S_RG_RD || state_r == S_RG_WB) ? cnt_r : idx_r;
  assign rd_lag  = lag_of(rd_addr);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    mag_nxt       = mag_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    stride_nxt    = stride_r;
    out_nxt       = out_r;
    alu_op        = ALU_SUBMOD;
    alu_a         = {1'b0, rd_a};
    alu_b         = rd_b;
    wr            = '0;
    out_valid_nxt = out_valid_r && !out_item.ready;

    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          if (in_item.kind == KIND_SEED) begin
            mag_nxt   = seed_mag;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_QUOT;
          end else begin
            state_nxt = S_NEXT_WB;
          end
        end
      end
      S_NEXT_WB: begin
        if (commit) begin
          wr            = '{en: 1'b1, addr: idx_r, data: alu_y};
          out_nxt       = alu_y;
          out_valid_nxt = 1'b1;
          idx_nxt       = (idx_r == LAST_IDX) ? '0 : idx_r + idx_t'(1);
          state_nxt     = S_IDLE;
        end
      end
      S_QUOT: begin
        quot_nxt  = quot_prod[2*SEED_W-1:SEED_W];
        state_nxt = S_BACK;
      end
      S_BACK: begin
        // partial remainder, below twice the modulus
        mag_nxt   = mag_r - back_prod;
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        // final compare and subtract of the seed remainder
        alu_op    = ALU_REDUCE;
        alu_a     = mag_r[WORD_W:0];
        rem_nxt   = alu_y;
        state_nxt = S_FILL_HEAD;
      end
      S_FILL_HEAD: begin
        wr         = '{en: 1'b1, addr: LAST_IDX, data: rem_r};
        cur_nxt    = word_t'(1);
        stride_nxt = IDX_W'(FILL_STRIDE);
        cnt_nxt    = idx_t'(1);
        state_nxt  = S_FILL;
      end
      S_FILL: begin
        wr         = '{en: 1'b1, addr: fill_slot, data: cur_r};
        alu_a      = {1'b0, rem_r};
        alu_b      = cur_r;
        cur_nxt    = alu_y;
        rem_nxt    = cur_r;
        stride_nxt = stride_sum[IDX_W-1:0];
        cnt_nxt    = cnt_r + idx_t'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_RG_RD;
        end
      end
      S_RG_RD: begin
        state_nxt = S_RG_WB;
      end
      S_RG_WB: begin
        wr = '{en: 1'b1, addr: cnt_r, data: alu_y};
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          if (pass_r) begin
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            pass_nxt  = 1'b1;
            state_nxt = S_RG_RD;
          end
        end else begin
          cnt_nxt   = cnt_r + idx_t'(1);
          state_nxt = S_RG_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers, reset starts the default seeding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_QUOT;
      idx_r       <= '0;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      mag_r       <= RESET_SEED;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      mag_r       <= mag_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quot_r   <= quot_nxt;
    cur_r    <= cur_nxt;
    stride_r <= stride_nxt;
    out_r    <= out_nxt;
  end

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("read index beyond table");

  a_wr_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ({1'b0, wr.data} < MOD_S))
    else $error("table write not reduced");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REDUCE) |-> (mag_r < MOD2))
    else $error("seed remainder not reduced");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_item.valid && (out_item.random_value == $past(alu_y)))
    else $error("result word not presented");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && in_item.kind == KIND_SEED) |=> !in_item.ready)
    else $error("ready during seeding");

endmodule
